@@ rtl/rgbc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbc_pkg
// Shared constants, kernel table and types of the 3x3 RGB emboss filter.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_PIXEL_BITS = 8;

  // result field widths
  localparam int SUM_W = 12;
  localparam int ROW_W = 12;
  localparam int COL_W = 11;

  // configuration register widths and limits
  localparam int CFG_W_BITS   = 12;
  localparam int CFG_H_BITS   = 13;
  localparam int MIN_DIM      = 3;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int WIDTH_RST    = 640;
  localparam int HEIGHT_RST   = 480;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // emboss kernel, row 0 weights the row above the center
  localparam int KERNEL [3][3] = '{'{-2, -1, 0}, '{-1, 1, 1}, '{0, 1, 2}};

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // per-pixel bookkeeping that travels with the window
  typedef struct packed {
    logic             fire;
    logic             eof;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tag_t;

endpackage

@@ rtl/rgbc_if.sv @@
// ----------------------------------------------------------------------------
// rgbc_if
// Valid/ready channels of the RGB filter: pixel input and result output.
// ----------------------------------------------------------------------------
interface rgbc_pix_if #(
  parameter int PIXEL_BITS = rgbc_pkg::DEF_PIXEL_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  first_of_frame;
  logic [PIXEL_BITS-1:0] red_in;
  logic [PIXEL_BITS-1:0] green_in;
  logic [PIXEL_BITS-1:0] blue_in;

  modport source (output valid, first_of_frame, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, first_of_frame, red_in, green_in, blue_in, output ready);
endinterface

interface rgbc_res_if ();
  logic                               valid;
  logic                               ready;
  logic signed [rgbc_pkg::SUM_W-1:0] red_sum;
  logic signed [rgbc_pkg::SUM_W-1:0] green_sum;
  logic signed [rgbc_pkg::SUM_W-1:0] blue_sum;
  logic        [rgbc_pkg::ROW_W-1:0] centre_row;
  logic        [rgbc_pkg::COL_W-1:0] centre_col;
  logic                               end_of_frame;

  modport source (output valid, red_sum, green_sum, blue_sum, centre_row, centre_col,
                  end_of_frame, input ready);
  modport sink   (input valid, red_sum, green_sum, blue_sum, centre_row, centre_col,
                  end_of_frame, output ready);
endinterface

@@ rtl/rgbc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rgbc_cfg_regs
// APB register file for image width and height, with range clamping.
// ----------------------------------------------------------------------------
module rgbc_cfg_regs #(
  parameter int MAX_WIDTH = rgbc_pkg::DEF_MAX_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rgbc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rgbc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rgbc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [$clog2(MAX_WIDTH):0]          eff_width,
  output logic [rgbc_pkg::CFG_H_BITS-1:0]     eff_height
);
  localparam int WB    = rgbc_pkg::CFG_W_BITS;
  localparam int HB    = rgbc_pkg::CFG_H_BITS;
  localparam int DW    = rgbc_pkg::APB_DATA_W;
  localparam int EW    = $clog2(MAX_WIDTH) + 1;
  localparam int CMP_W = (EW > WB) ? EW : WB;

  logic [WB-1:0]     width_r;
  logic [HB-1:0]     height_r;
  logic              wr_en;
  logic [CMP_W-1:0]  w_ext;
  rgbc_pkg::reg_idx_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = rgbc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WB'(rgbc_pkg::WIDTH_RST);
      height_r <= HB'(rgbc_pkg::HEIGHT_RST);
    end else if (wr_en) begin
      case (reg_sel)
        rgbc_pkg::REG_WIDTH:  width_r  <= pwdata[WB-1:0];
        rgbc_pkg::REG_HEIGHT: height_r <= pwdata[HB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      rgbc_pkg::REG_WIDTH:  prdata = DW'(width_r);
      rgbc_pkg::REG_HEIGHT: prdata = DW'(height_r);
      default:              prdata = '0;
    endcase
  end

  // clamp to the supported frame size
  assign w_ext = CMP_W'(width_r);

  always_comb begin
    if (w_ext < CMP_W'(rgbc_pkg::MIN_DIM)) begin
      eff_width = EW'(rgbc_pkg::MIN_DIM);
    end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(w_ext);
    end
    if (height_r < HB'(rgbc_pkg::MIN_DIM)) begin
      eff_height = HB'(rgbc_pkg::MIN_DIM);
    end else if (height_r > HB'(rgbc_pkg::HEIGHT_LIMIT)) begin
      eff_height = HB'(rgbc_pkg::HEIGHT_LIMIT);
    end else begin
      eff_height = height_r;
    end
  end

endmodule

@@ rtl/rgbc_line_buf.sv @@
// ----------------------------------------------------------------------------
// rgbc_line_buf
// Two line stores of RGB words, read on accept and written one stage later.
// ----------------------------------------------------------------------------
module rgbc_line_buf #(
  parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = rgbc_pkg::DEF_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  input  logic [3*PIXEL_BITS-1:0]       wr_px,
  output logic [3*PIXEL_BITS-1:0]       up_o,
  output logic [3*PIXEL_BITS-1:0]       lo_o
);
  localparam int DW = 3 * PIXEL_BITS;

  logic [DW-1:0] upper_mem [MAX_WIDTH];
  logic [DW-1:0] lower_mem [MAX_WIDTH];
  logic [DW-1:0] up_q_r;
  logic [DW-1:0] lo_q_r;
  logic [DW-1:0] byp_up_r;
  logic [DW-1:0] byp_lo_r;
  logic          byp_r;
  logic          byp_nxt;

  // a write landing on the address read in the same cycle is forwarded
  assign byp_nxt = wr_en && (wr_addr == rd_addr);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= lo_o;
      lower_mem[wr_addr] <= wr_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q_r   <= upper_mem[rd_addr];
      lo_q_r   <= lower_mem[rd_addr];
      byp_up_r <= lo_o;
      byp_lo_r <= wr_px;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= byp_nxt;
    end
  end

  assign up_o = byp_r ? byp_up_r : up_q_r;
  assign lo_o = byp_r ? byp_lo_r : lo_q_r;

  a_bypass_taken: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && byp_nxt |=> byp_r && (lo_o == $past(wr_px)))
    else $error("line buffer forwarding missed a same-address write");

endmodule

@@ rtl/rgbc_win_sum.sv @@
// ----------------------------------------------------------------------------
// rgbc_win_sum
// 3x3 window registers, emboss sums per channel and the result register.
// ----------------------------------------------------------------------------
module rgbc_win_sum #(
  parameter int PIXEL_BITS = rgbc_pkg::DEF_PIXEL_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     shift_en,
  input  logic [3*PIXEL_BITS-1:0]  up_i,
  input  logic [3*PIXEL_BITS-1:0]  lo_i,
  input  logic [3*PIXEL_BITS-1:0]  px_i,
  input  rgbc_pkg::tag_t           tag_i,
  output logic                     s2_free,
  rgbc_res_if.source               out_res
);
  localparam int P     = PIXEL_BITS;
  localparam int DW    = 3 * P;
  localparam int SW    = rgbc_pkg::SUM_W;
  localparam int ACC_W = (P + 4 > SW) ? P + 4 : SW;

  logic [DW-1:0]  win_r [3][3];
  rgbc_pkg::tag_t s2_tag_r;
  logic           s2_v_r;
  logic           out_v_r;
  logic           out_free;
  logic           out_load;
  logic [SW-1:0]  sum_c [3];
  logic [SW-1:0]  red_sum_r;
  logic [SW-1:0]  green_sum_r;
  logic [SW-1:0]  blue_sum_r;
  logic [rgbc_pkg::ROW_W-1:0] row_r;
  logic [rgbc_pkg::COL_W-1:0] col_r;
  logic           eof_r;

  assign out_free = !out_v_r || out_res.ready;
  assign s2_free  = !s2_v_r || !s2_tag_r.fire || out_free;
  assign out_load = s2_v_r && s2_tag_r.fire && out_free;

  // shift one column left, new column enters on the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int dr = 0; dr < 3; dr++) begin
        win_r[dr][0] <= win_r[dr][1];
        win_r[dr][1] <= win_r[dr][2];
      end
      win_r[0][2] <= up_i;
      win_r[1][2] <= lo_i;
      win_r[2][2] <= px_i;
      s2_tag_r    <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (shift_en) begin
      s2_v_r <= 1'b1;
    end else if (s2_free) begin
      s2_v_r <= 1'b0;
    end
  end

  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic        [P-1:0]     pix;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          pix = win_r[dr][dc][k*P +: P];
          acc = acc + ACC_W'(rgbc_pkg::KERNEL[dr][dc]) * signed'(ACC_W'(pix));
        end
      end
      sum_c[k] = acc[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red_sum_r   <= sum_c[0];
      green_sum_r <= sum_c[1];
      blue_sum_r  <= sum_c[2];
      row_r       <= s2_tag_r.row;
      col_r       <= s2_tag_r.col;
      eof_r       <= s2_tag_r.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_res.ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_res.valid        = out_v_r;
  assign out_res.red_sum      = signed'(red_sum_r);
  assign out_res.green_sum    = signed'(green_sum_r);
  assign out_res.blue_sum     = signed'(blue_sum_r);
  assign out_res.centre_row   = row_r;
  assign out_res.centre_col   = col_r;
  assign out_res.end_of_frame = eof_r;

  a_no_shift_on_pending: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_tag_r.fire && out_v_r && !out_res.ready |-> !shift_en)
    else $error("window shifted while its result was still pending");

endmodule

@@ rtl/rgb_convolution_3x3.sv @@
// ----------------------------------------------------------------------------
// rgb_convolution_3x3
// Streaming 3x3 emboss filter over RGB pixels in raster order.
//
//   channel   dir  handshake     payload
//   in_pix    in   valid/ready   first_of_frame, red_in, green_in, blue_in
//   out_res   out  valid/ready   red/green/blue_sum, centre_row/col, end_of_frame
//   cfg       in   APB           image_width @0x0, image_height @0x4
//
// One pixel per clock while no stage stalls. A pixel's result is formed through
// the line store read register, then the window register, then the result
// register. A stalled result holds the window; border pixels still move through
// while it waits. Reset clears the control state only; the line stores need no
// clearing pass, as each entry a sum uses is written within its frame first.
// ----------------------------------------------------------------------------
module rgb_convolution_3x3 #(
  parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = rgbc_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rgbc_pix_if.sink                        in_pix,
  rgbc_res_if.source                      out_res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rgbc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rgbc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rgbc_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = rgbc_pkg::CFG_H_BITS;
  localparam int ROW_W = rgbc_pkg::ROW_W;
  localparam int COL_W = rgbc_pkg::COL_W;
  localparam int DW    = 3 * PIXEL_BITS;

  logic [CW:0]       eff_w;
  logic [HW-1:0]     eff_h;
  logic              in_ready;
  logic              accept;
  logic              s2_free;
  logic              s1_adv;
  logic [CW-1:0]     col_r;
  logic [CW-1:0]     col_nxt;
  logic [CW-1:0]     c_cur;
  logic [CW:0]       c_inc;
  logic [ROW_W-1:0]  row_r;
  logic [ROW_W-1:0]  row_nxt;
  logic [ROW_W-1:0]  r_cur;
  logic [HW-1:0]     r_inc;
  logic [DW-1:0]     px_c;
  rgbc_pkg::tag_t    tag_c;
  logic              s1_v_r;
  logic [DW-1:0]     s1_px_r;
  logic [CW-1:0]     s1_addr_r;
  rgbc_pkg::tag_t    s1_tag_r;
  logic [DW-1:0]     up_w;
  logic [DW-1:0]     lo_w;

  rgbc_cfg_regs #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .eff_width  (eff_w),
    .eff_height (eff_h)
  );

  assign s1_adv       = s1_v_r && s2_free;
  assign in_ready     = !s1_v_r || s2_free;
  assign in_pix.ready = in_ready;
  assign accept       = in_pix.valid && in_ready;
  assign px_c         = {in_pix.blue_in, in_pix.green_in, in_pix.red_in};

  // position of this pixel and where the next one lands
  always_comb begin
    c_cur = in_pix.first_of_frame ? '0 : col_r;
    r_cur = in_pix.first_of_frame ? '0 : row_r;
    c_inc = {1'b0, c_cur} + (CW+1)'(1);
    r_inc = HW'(r_cur) + HW'(1);
    if (c_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (r_inc >= eff_h) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_nxt = c_inc[CW-1:0];
      row_nxt = r_cur;
    end
    tag_c.fire = (r_cur >= ROW_W'(2)) && (c_cur >= CW'(2)) &&
                 (HW'(r_cur) < eff_h) && ({1'b0, c_cur} < eff_w);
    tag_c.eof  = (HW'(r_cur) == eff_h - HW'(1)) && ({1'b0, c_cur} == eff_w - (CW+1)'(1));
    tag_c.row  = r_cur - ROW_W'(1);
    tag_c.col  = COL_W'(c_cur - CW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= px_c;
      s1_addr_r <= c_cur;
      s1_tag_r  <= tag_c;
    end
  end

  rgbc_line_buf #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_lbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (c_cur),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_px   (s1_px_r),
    .up_o    (up_w),
    .lo_o    (lo_w)
  );

  rgbc_win_sum #(.PIXEL_BITS(PIXEL_BITS)) u_win (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_adv),
    .up_i     (up_w),
    .lo_i     (lo_w),
    .px_i     (s1_px_r),
    .tag_i    (s1_tag_r),
    .s2_free  (s2_free),
    .out_res  (out_res)
  );

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_pix.first_of_frame |=> col_r == CW'(1))
    else $error("column counter did not restart on frame start");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_v_r)
    else $error("input stalled with an empty first stage");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_free |=> s1_v_r && $stable(s1_addr_r) && $stable(s1_px_r))
    else $error("first stage lost its word while stalled");

endmodule

@@ test/rgb_convolution_3x3_test.sv @@
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_test
// Self-checking bench for the streaming 3x3 emboss filter. A software copy of
// the line stores and window predicts every interior sum. Stimulus starts with
// a short border-only run at the reset geometry, then covers a mid-frame shrink
// of both sizes, a 3x3 frame with saturating pixels, tall, wide and clamped
// sizes, and then random small frames. Some of those frames are cut short or
// carry stray frame starts. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rgb_convolution_3x3_test;

  localparam int STALL_LIMIT   = 1000;
  localparam int RANDOM_ITEMS  = 600;
  localparam int SETTLE_CYCLES = 6;
  localparam int RESET_RUN     = 24;

  // edge geometries: register values written and extra pixels past one frame
  localparam int EDGE_W [4] = '{0, 12, 2, 3};
  localparam int EDGE_H [4] = '{12, 1, 0, 2};
  localparam int EDGE_EXTRA [4] = '{0, 0, 0, 9};

  typedef logic [2:0][7:0] rgb_word_t;  // [0] red, [1] green, [2] blue

  typedef struct packed {
    logic signed [rgbc_pkg::SUM_W-1:0] red_sum;
    logic signed [rgbc_pkg::SUM_W-1:0] green_sum;
    logic signed [rgbc_pkg::SUM_W-1:0] blue_sum;
    logic        [rgbc_pkg::ROW_W-1:0] centre_row;
    logic        [rgbc_pkg::COL_W-1:0] centre_col;
    logic                              end_of_frame;
  } sum_report_t;

  class emboss_board;
    logic [rgbc_pkg::CFG_W_BITS-1:0] width_reg;
    logic [rgbc_pkg::CFG_H_BITS-1:0] height_reg;
    rgb_word_t upper_row [rgbc_pkg::DEF_MAX_WIDTH];
    rgb_word_t lower_row [rgbc_pkg::DEF_MAX_WIDTH];
    rgb_word_t win [3][3];
    int unsigned col_pos;
    int unsigned row_pos;
    sum_report_t pending_sums [$];
    int errors;

    function new();
      width_reg  = rgbc_pkg::WIDTH_RST;
      height_reg = rgbc_pkg::HEIGHT_RST;
      col_pos    = 0;
      row_pos    = 0;
      errors     = 0;
      foreach (win[i, j]) win[i][j] = '0;
      foreach (upper_row[i]) begin
        upper_row[i] = '0;
        lower_row[i] = '0;
      end
    endfunction

    function void set_reg(rgbc_pkg::reg_idx_t idx, int unsigned value);
      case (idx)
        rgbc_pkg::REG_WIDTH:  width_reg  = value[rgbc_pkg::CFG_W_BITS-1:0];
        rgbc_pkg::REG_HEIGHT: height_reg = value[rgbc_pkg::CFG_H_BITS-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < rgbc_pkg::MIN_DIM) return rgbc_pkg::MIN_DIM;
      if (width_reg > rgbc_pkg::DEF_MAX_WIDTH) return rgbc_pkg::DEF_MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned eff_height();
      if (height_reg < rgbc_pkg::MIN_DIM) return rgbc_pkg::MIN_DIM;
      if (height_reg > rgbc_pkg::HEIGHT_LIMIT) return rgbc_pkg::HEIGHT_LIMIT;
      return 32'(height_reg);
    endfunction

    function void note_pixel(logic fof, rgb_word_t px);
      int unsigned w, h, c, r;
      int sums [3];
      rgb_word_t up, lo;
      sum_report_t want;
      w = eff_width();
      h = eff_height();
      if (fof) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      up = '0;
      lo = '0;
      if (c < rgbc_pkg::DEF_MAX_WIDTH) begin
        up = upper_row[c];
        lo = lower_row[c];
        upper_row[c] = lo;
        lower_row[c] = px;
      end
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = up;
      win[1][2] = lo;
      win[2][2] = px;
      // interior centers only; the sum belongs to the pixel one up and one left
      if (r >= 2 && c >= 2 && r < h && c < w) begin
        for (int k = 0; k < 3; k++) begin
          sums[k] = 0;
          for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
              sums[k] += rgbc_pkg::KERNEL[i][j] * int'(win[i][j][k]);
        end
        want.red_sum      = sums[0][rgbc_pkg::SUM_W-1:0];
        want.green_sum    = sums[1][rgbc_pkg::SUM_W-1:0];
        want.blue_sum     = sums[2][rgbc_pkg::SUM_W-1:0];
        want.centre_row   = rgbc_pkg::ROW_W'(r - 1);
        want.centre_col   = rgbc_pkg::COL_W'(c - 1);
        want.end_of_frame = (r == h - 1 && c == w - 1);
        pending_sums.push_back(want);
      end
      // a counter past a shrunken size wraps on this advance
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void compare_field(string label, integer want, integer got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        errors++;
      end
    endfunction

    function void check_result(sum_report_t got);
      sum_report_t want;
      if (pending_sums.size() == 0) begin
        $display("%0t: result expected none, got row %0d col %0d",
                 $time, got.centre_row, got.centre_col);
        errors++;
        return;
      end
      want = pending_sums.pop_front();
      compare_field("red_sum", want.red_sum, got.red_sum);
      compare_field("green_sum", want.green_sum, got.green_sum);
      compare_field("blue_sum", want.blue_sum, got.blue_sum);
      compare_field("centre_row", want.centre_row, got.centre_row);
      compare_field("centre_col", want.centre_col, got.centre_col);
      compare_field("end_of_frame", want.end_of_frame, got.end_of_frame);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rgbc_pkg::APB_ADDR_W-1:0] paddr;
  logic [rgbc_pkg::APB_DATA_W-1:0] pwdata;
  logic [rgbc_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  rgbc_pix_if pix ();
  rgbc_res_if res ();

  emboss_board board = new();
  sum_report_t seen_sum;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  rgb_convolution_3x3 dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_res (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // note accepted pixels before checking results of the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix.valid && pix.ready)
        board.note_pixel(pix.first_of_frame, {pix.blue_in, pix.green_in, pix.red_in});
      if (res.valid && res.ready) begin
        seen_sum = {res.red_sum, res.green_sum, res.blue_sum, res.centre_row,
                    res.centre_col, res.end_of_frame};
        board.check_result(seen_sum);
      end
    end
  end

  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: stall a random number of cycles before each word
  initial begin
    int stall;
    res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!(res.valid && res.ready));
    end
  end

  function automatic rgb_word_t rand_pixel();
    rgb_word_t px;
    for (int k = 0; k < 3; k++)
      px[k] = ($urandom_range(0, 4) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                          : 8'($urandom);
    return px;
  endfunction

  task automatic push_pixel(input logic fof, input rgb_word_t px);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid          <= 1'b1;
    pix.first_of_frame <= fof;
    pix.red_in         <= px[0];
    pix.green_in       <= px[1];
    pix.blue_in        <= px[2];
    do @(posedge clk); while (!(pix.valid && pix.ready));
  endtask

  // noisy runs drop stray frame starts after the first word
  task automatic push_run(input int count, input logic fof_first, input bit noisy);
    for (int i = 0; i < count; i++)
      push_pixel((i == 0) ? fof_first : (noisy && $urandom_range(0, 7) == 0), rand_pixel());
  endtask

  // drain all pending sums, then give the pipeline time to empty
  task automatic settle();
    pix.valid <= 1'b0;
    while (board.pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // return the bus to idle after the access phase
  task automatic apb_write(input rgbc_pkg::reg_idx_t idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.set_reg(idx, value);
    @(posedge clk);
  endtask

  initial begin
    int random_items;
    int frame_len;
    int len;
    int pick;
    bit whole;
    rgb_word_t px;

    rst_n              <= 1'b0;
    pix.valid          <= 1'b0;
    pix.first_of_frame <= 1'b0;
    pix.red_in         <= '0;
    pix.green_in       <= '0;
    pix.blue_in        <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: part of the first row, border only
    push_run(RESET_RUN, 1'b1, 1'b0);
    settle();

    // shrink width while the column is past the new end, then height likewise
    apb_write(rgbc_pkg::REG_WIDTH, 4);
    apb_write(rgbc_pkg::REG_HEIGHT, 5);
    push_run(11, 1'b1, 1'b0);
    settle();
    apb_write(rgbc_pkg::REG_WIDTH, 3);
    push_run(4, 1'b0, 1'b0);
    settle();
    apb_write(rgbc_pkg::REG_HEIGHT, 3);
    push_run(3, 1'b0, 1'b0);
    settle();

    // clamped 3x3 frame: red at its largest sum, green at its smallest
    apb_write(rgbc_pkg::REG_WIDTH, 1);
    apb_write(rgbc_pkg::REG_HEIGHT, 2);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        px[0] = (rgbc_pkg::KERNEL[i][j] > 0) ? 8'hFF : 8'h00;
        px[1] = (rgbc_pkg::KERNEL[i][j] < 0) ? 8'hFF : 8'h00;
        px[2] = 8'hFF;
        push_pixel(i == 0 && j == 0, px);
      end
    end
    settle();

    // tall, wide and clamped geometries, one frame each, the last with extra pixels
    for (int b = 0; b < 4; b++) begin
      calm = ($urandom_range(0, 1) == 0);
      apb_write(rgbc_pkg::REG_WIDTH, EDGE_W[b]);
      apb_write(rgbc_pkg::REG_HEIGHT, EDGE_H[b]);
      push_run(board.eff_width() * board.eff_height() + EDGE_EXTRA[b], 1'b1, 1'b0);
      settle();
    end

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      apb_write(rgbc_pkg::REG_WIDTH, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                 : $urandom_range(3, 10));
      apb_write(rgbc_pkg::REG_HEIGHT, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                  : $urandom_range(3, 7));
      frame_len = board.eff_width() * board.eff_height();
      whole = 1'b0;
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          len = $urandom_range(1, frame_len);
          push_run(len, 1'b1, 1'b1);
          whole = 1'b0;
        end else if (pick <= 2) begin
          len = $urandom_range(1, frame_len - 1);
          push_run(len, 1'b1, 1'b0);
          whole = 1'b0;
        end else begin
          // after a whole frame, let the counters wrap into the next one
          len = frame_len;
          push_run(len, !whole || $urandom_range(0, 1), 1'b0);
          whole = 1'b1;
        end
        random_items += len;
      end
      settle();
    end

    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ rgb_convolution_3x3.f @@
rtl/rgbc_pkg.sv
rtl/rgbc_if.sv
rtl/rgbc_cfg_regs.sv
rtl/rgbc_line_buf.sv
rtl/rgbc_win_sum.sv
rtl/rgb_convolution_3x3.sv
test/rgb_convolution_3x3_test.sv
